// ----- design/nearest_request_scheduler_assert.svh -----
`ifndef NEAREST_REQUEST_SCHEDULER_ASSERT_SVH
`define NEAREST_REQUEST_SCHEDULER_ASSERT_SVH
// concurrent check of an implication under reset
`define NRS_ASSERT_IMP(label, clk, rst_n, lhs, rhs) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
		else $error("%m: check failed");
// check of a next-cycle implication under reset
`define NRS_ASSERT_NXT(label, clk, rst_n, lhs, rhs) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
		else $error("%m: check failed");
`endif

// ----- design/nrs_pkg.sv -----
`timescale 1ns / 1ps
package nrs_pkg;
	localparam int SUM_BITS = 48;
	localparam int STATUS_BITS = 2;
	localparam int OUT_POS_BITS = 16;
	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_SERVE = 1'b1;
	typedef enum logic [STATUS_BITS-1:0] {
		ST_INSERTED = 2'd0,
		ST_SERVED = 2'd1,
		ST_EMPTY = 2'd2,
		ST_FULL = 2'd3
	} status_t;
endpackage

// ----- design/nrs_queue.sv -----
`timescale 1ns / 1ps
module nrs_queue import nrs_pkg::*; #(
	parameter int WIDTH = 17
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] dout,
	output logic             empty
);
	logic [1:0][WIDTH-1:0] mem_q;
	logic [1:0] cnt_q;
	logic wr_ptr_q, rd_ptr_q;
	logic do_push, do_pop;

	assign full = cnt_q[1];
	assign empty = (cnt_q == 2'd0);
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign dout = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
		end else begin
			if (do_push) wr_ptr_q <= ~wr_ptr_q;
			if (do_pop) rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= din;
	end
endmodule

// ----- design/nrs_engine.sv -----
`timescale 1ns / 1ps
module nrs_engine import nrs_pkg::*; #(
	parameter int TABLE_ENTRIES = 64,
	parameter int POSITION_BITS = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cmd_valid,
	input  logic                     cmd_op,
	input  logic [POSITION_BITS-1:0] cmd_pos,
	output logic                     cmd_pop,
	output logic                     res_valid,
	input  logic                     res_pop,
	output status_t                  res_status,
	output logic [OUT_POS_BITS-1:0]  res_served,
	output logic [OUT_POS_BITS-1:0]  res_dist,
	output logic [SUM_BITS-1:0]      res_total
);
	localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CW = $clog2(TABLE_ENTRIES + 1);
	localparam logic [CW-1:0] LAST = CW'(TABLE_ENTRIES - 1);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_SCAN  = 5'b00010,
		S_PICK  = 5'b00100,
		S_MOVE  = 5'b01000,
		S_OUT   = 5'b10000
	} state_t;

	state_t state_q;
	logic [POSITION_BITS-1:0] mem [TABLE_ENTRIES];
	logic [TABLE_ENTRIES-1:0] valid_q;
	logic [POSITION_BITS-1:0] rd_q, head_q, up_q, lo_q, pick_q, dist_q;
	logic [CW-1:0] idx_q;
	logic [IW-1:0] rd_idx_q, up_idx_q, lo_idx_q, pick_idx_q;
	logic rd_vld_q, have_up_q, have_lo_q, up_q_dir, scan_done_q;
	logic [SUM_BITS-1:0] sum_q;
	logic [IW-1:0] free_idx;
	logic free_any;
	logic [POSITION_BITS-1:0] dup, dlo;
	logic pick_up;
	logic [SUM_BITS:0] sum_add;

	always_comb begin
		free_any = 1'b0;
		free_idx = '0;
		for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_any = 1'b1;
				free_idx = IW'(i);
			end
		end
	end

	assign dup = up_q - head_q;
	assign dlo = head_q - lo_q;
	always_comb begin
		if (!have_lo_q) pick_up = 1'b1;
		else if (!have_up_q) pick_up = 1'b0;
		else if (dup < dlo) pick_up = 1'b1;
		else if (dlo < dup) pick_up = 1'b0;
		else pick_up = up_q_dir;
	end
	assign sum_add = {1'b0, sum_q} + (SUM_BITS + 1)'(dist_q);

	assign cmd_pop = (state_q == S_IDLE) && cmd_valid && !res_valid;

	always_ff @(posedge clk) begin
		if (cmd_pop && cmd_op == OP_INSERT && free_any) mem[free_idx] <= cmd_pos;
		rd_q <= mem[IW'(idx_q)];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			valid_q <= '0;
			head_q <= '0;
			up_q_dir <= 1'b1;
			sum_q <= '0;
			res_valid <= 1'b0;
			res_status <= ST_INSERTED;
			res_served <= '0;
			res_dist <= '0;
			res_total <= '0;
			idx_q <= '0;
			rd_idx_q <= '0;
			rd_vld_q <= 1'b0;
			scan_done_q <= 1'b0;
			have_up_q <= 1'b0;
			have_lo_q <= 1'b0;
			up_q <= '0;
			lo_q <= '0;
			pick_q <= '0;
			dist_q <= '0;
			up_idx_q <= '0;
			lo_idx_q <= '0;
			pick_idx_q <= '0;
		end else begin
			if (res_valid && res_pop) res_valid <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (cmd_pop) begin
						res_served <= '0;
						res_dist <= '0;
						if (cmd_op == OP_INSERT) begin
							if (free_any) begin
								valid_q[free_idx] <= 1'b1;
								res_status <= ST_INSERTED;
							end else begin
								res_status <= ST_FULL;
							end
							res_total <= sum_q;
							res_valid <= 1'b1;
						end else begin
							state_q <= S_SCAN;
							idx_q <= '0;
							rd_idx_q <= '0;
							rd_vld_q <= 1'b0;
							scan_done_q <= 1'b0;
							have_up_q <= 1'b0;
							have_lo_q <= 1'b0;
						end
					end
				end
				S_SCAN: begin
					rd_vld_q <= !scan_done_q && valid_q[IW'(idx_q)];
					rd_idx_q <= IW'(idx_q);
					if (rd_vld_q) begin
						if (rd_q >= head_q) begin
							if (!have_up_q || rd_q < up_q) begin
								up_q <= rd_q;
								up_idx_q <= rd_idx_q;
								have_up_q <= 1'b1;
							end
						end else if (!have_lo_q || rd_q > lo_q) begin
							lo_q <= rd_q;
							lo_idx_q <= rd_idx_q;
							have_lo_q <= 1'b1;
						end
					end
					if (idx_q == LAST) scan_done_q <= 1'b1;
					else if (!scan_done_q) idx_q <= idx_q + CW'(1);
					if (scan_done_q && !rd_vld_q) state_q <= S_PICK;
				end
				S_PICK: begin
					if (!have_up_q && !have_lo_q) begin
						res_status <= ST_EMPTY;
						res_total <= sum_q;
						res_valid <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						pick_q <= pick_up ? up_q : lo_q;
						pick_idx_q <= pick_up ? up_idx_q : lo_idx_q;
						dist_q <= pick_up ? dup : dlo;
						state_q <= S_MOVE;
					end
				end
				S_MOVE: begin
					valid_q[pick_idx_q] <= 1'b0;
					if (pick_q > head_q) up_q_dir <= 1'b1;
					else if (pick_q < head_q) up_q_dir <= 1'b0;
					head_q <= pick_q;
					sum_q <= sum_add[SUM_BITS] ? '1 : sum_add[SUM_BITS-1:0];
					state_q <= S_OUT;
				end
				S_OUT: begin
					res_status <= ST_SERVED;
					res_served <= OUT_POS_BITS'(pick_q);
					res_dist <= OUT_POS_BITS'(dist_q);
					res_total <= sum_q;
					res_valid <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ----- design/nearest_request_scheduler.sv -----
`timescale 1ns / 1ps
// channel | direction | handshake         | fields
// input   | in        | push / full       | op, position
// result  | out       | pop / empty       | status, served_position, move_distance, total_distance
// insert: the command passes the input queue, and the result word is registered when the engine takes it
// serve: one table entry read per cycle, then the pick, move and output states
//   register the result word
// the back end holds one finished word and waits while it is not taken
// arst_n clears the table valid bits, head and total and sets the direction to up at once
module nearest_request_scheduler import nrs_pkg::*; #(
	parameter int TABLE_ENTRIES = 64,
	parameter int POSITION_BITS = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	output logic                     full,
	input  logic                     op,
	input  logic [POSITION_BITS-1:0] position,
	output logic                     empty,
	input  logic                     pop,
	output logic [STATUS_BITS-1:0]   status,
	output logic [OUT_POS_BITS-1:0]  served_position,
	output logic [OUT_POS_BITS-1:0]  move_distance,
	output logic [SUM_BITS-1:0]      total_distance
);
	logic q_empty, q_pop, res_valid;
	logic [POSITION_BITS:0] q_dout;
	status_t res_status;

	nrs_queue #(.WIDTH(POSITION_BITS + 1)) u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .din({op, position}), .full(full),
		.pop(q_pop), .dout(q_dout), .empty(q_empty)
	);

	nrs_engine #(.TABLE_ENTRIES(TABLE_ENTRIES), .POSITION_BITS(POSITION_BITS)) u_engine (
		.clk(clk), .arst_n(arst_n), .cmd_valid(!q_empty),
		.cmd_op(q_dout[POSITION_BITS]), .cmd_pos(q_dout[POSITION_BITS-1:0]),
		.cmd_pop(q_pop), .res_valid(res_valid), .res_pop(pop),
		.res_status(res_status), .res_served(served_position),
		.res_dist(move_distance), .res_total(total_distance)
	);

	assign empty = !res_valid;
	assign status = res_status;
endmodule

// ----- design/nrs_checker.sv -----
`timescale 1ns / 1ps
`include "nearest_request_scheduler_assert.svh"
module nrs_checker import nrs_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        empty,
	input logic        pop,
	input logic [1:0]  status,
	input logic [15:0] served_position,
	input logic [15:0] move_distance,
	input logic [47:0] total_distance
);
	`NRS_ASSERT_IMP(a_zero_when_not_served, clk, arst_n,
		!empty && status != ST_SERVED, served_position == '0 && move_distance == '0)
	`NRS_ASSERT_NXT(a_hold_while_waiting, clk, arst_n,
		!empty && !pop, !empty && $stable(total_distance) && $stable(status))
	`NRS_ASSERT_NXT(a_total_no_decrease, clk, arst_n,
		!empty && pop, empty || total_distance >= $past(total_distance))
endmodule

bind nearest_request_scheduler nrs_checker u_nrs_checker (
	.clk(clk), .arst_n(arst_n), .empty(empty), .pop(pop), .status(status),
	.served_position(served_position), .move_distance(move_distance),
	.total_distance(total_distance)
);

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
	import nrs_pkg::*;

	localparam int ENTRIES = 64;
	localparam int POS_BITS = 16;
	localparam int RANDOM_ITEMS = 1650;
	localparam int CYCLE_LIMIT = 2000000;
	localparam logic [SUM_BITS-1:0] SUM_CAP = {SUM_BITS{1'b1}};

	typedef struct {
		logic                op;
		logic [POS_BITS-1:0] pos;
	} request_t;

	typedef struct {
		status_t                 st;
		logic [OUT_POS_BITS-1:0] served;
		logic [OUT_POS_BITS-1:0] travel;
		logic [SUM_BITS-1:0]     total;
	} outcome_t;

	logic                    clk;
	logic                    arst_n;
	logic                    push = 1'b0;
	logic                    full;
	logic                    op = OP_INSERT;
	logic [POS_BITS-1:0]     position = '0;
	logic                    empty;
	logic                    pop = 1'b0;
	logic [STATUS_BITS-1:0]  status;
	logic [OUT_POS_BITS-1:0] served_position;
	logic [OUT_POS_BITS-1:0] move_distance;
	logic [SUM_BITS-1:0]     total_distance;

	request_t request_q[$];
	outcome_t outcome_q[$];

	logic [POS_BITS-1:0] slot_pos[ENTRIES];
	logic                slot_used[ENTRIES];
	logic [POS_BITS-1:0] head_pos;
	logic                heading_up;
	logic [SUM_BITS-1:0] travel_sum;

	int total_items;
	int sent_cnt = 0;
	int hold_at;
	logic hold_done = 1'b0;
	int errors = 0;
	int cycles = 0;
	int status_cnt[4];

	nearest_request_scheduler i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.op(op),
		.position(position),
		.empty(empty),
		.pop(pop),
		.status(status),
		.served_position(served_position),
		.move_distance(move_distance),
		.total_distance(total_distance)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic schedule_predict(input logic cmd, input logic [POS_BITS-1:0] pos);
		outcome_t o;
		int free_slot;
		logic got_up, got_lo;
		logic [POS_BITS-1:0] up, lo, pick, d_up, d_lo;
		free_slot = -1;
		got_up = 1'b0;
		got_lo = 1'b0;
		up = '0;
		lo = '0;
		o.served = '0;
		o.travel = '0;
		if (cmd == OP_INSERT) begin
			for (int i = 0; i < ENTRIES; i++)
				if (!slot_used[i] && free_slot < 0)
					free_slot = i;
			if (free_slot < 0) begin
				o.st = ST_FULL;
			end else begin
				slot_pos[free_slot] = pos;
				slot_used[free_slot] = 1'b1;
				o.st = ST_INSERTED;
			end
		end else begin
			for (int i = 0; i < ENTRIES; i++) begin
				if (slot_used[i]) begin
					if (slot_pos[i] >= head_pos) begin
						if (!got_up || slot_pos[i] < up) begin
							up = slot_pos[i];
							got_up = 1'b1;
						end
					end else if (!got_lo || slot_pos[i] > lo) begin
						lo = slot_pos[i];
						got_lo = 1'b1;
					end
				end
			end
			if (!got_up && !got_lo) begin
				o.st = ST_EMPTY;
			end else begin
				if (!got_lo) begin
					pick = up;
				end else if (!got_up) begin
					pick = lo;
				end else begin
					d_up = up - head_pos;
					d_lo = head_pos - lo;
					if (d_up < d_lo)
						pick = up;
					else if (d_lo < d_up)
						pick = lo;
					else
						pick = heading_up ? up : lo;
				end
				if (pick > head_pos) begin
					heading_up = 1'b1;
					o.travel = pick - head_pos;
				end else if (pick < head_pos) begin
					heading_up = 1'b0;
					o.travel = head_pos - pick;
				end
				free_slot = -1;
				for (int i = 0; i < ENTRIES; i++)
					if (slot_used[i] && slot_pos[i] == pick && free_slot < 0)
						free_slot = i;
				slot_used[free_slot] = 1'b0;
				head_pos = pick;
				if (SUM_CAP - travel_sum < SUM_BITS'(o.travel))
					travel_sum = SUM_CAP;
				else
					travel_sum = travel_sum + SUM_BITS'(o.travel);
				o.served = pick;
				o.st = ST_SERVED;
			end
		end
		o.total = travel_sum;
		outcome_q.push_back(o);
	endtask

	function automatic logic [POS_BITS-1:0] pick_position(input logic [POS_BITS-1:0] base);
		case ($urandom_range(0, 3))
			0: pick_position = POS_BITS'($urandom_range(0, 65535));
			1: pick_position = base + POS_BITS'($urandom_range(0, 40)) - POS_BITS'(20);
			2: pick_position = $urandom_range(0, 1) ? '1 : '0;
			default: pick_position = base + POS_BITS'($urandom_range(0, 3) * 8);
		endcase
	endfunction

	task automatic add_item(input logic cmd, input logic [POS_BITS-1:0] pos);
		request_t r;
		r.op = cmd;
		r.pos = pos;
		request_q.push_back(r);
	endtask

	function automatic bit sender_idles();
		int phase;
		phase = sent_cnt < total_items / 3 ? 0 : (sent_cnt < 2 * total_items / 3 ? 1 : 2);
		case (phase)
			0: sender_idles = $urandom_range(0, 99) < 14;
			1: sender_idles = $urandom_range(0, 99) < 73;
			default: sender_idles = 0;
		endcase
	endfunction

	function automatic bit receiver_idles();
		int phase;
		phase = sent_cnt < total_items / 3 ? 0 : (sent_cnt < 2 * total_items / 3 ? 1 : 2);
		case (phase)
			0: receiver_idles = $urandom_range(0, 99) < 73;
			1: receiver_idles = $urandom_range(0, 99) < 14;
			default: receiver_idles = 0;
		endcase
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push <= 1'b0;
			op <= OP_INSERT;
			position <= '0;
		end else begin
			if (push && !full)
				schedule_predict(op, position);
			if (!push || !full) begin
				if (sent_cnt == hold_at && !hold_done) begin
					push <= 1'b0;
					if (outcome_q.size() == 0)
						hold_done <= 1'b1;
				end else if (request_q.size() > 0 && !sender_idles()) begin
					push <= 1'b1;
					op <= request_q[0].op;
					position <= request_q[0].pos;
					void'(request_q.pop_front());
					sent_cnt <= sent_cnt + 1;
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				if (outcome_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected word: status %0d pos %0d", status, served_position);
				end else begin
					status_cnt[outcome_q[0].st]++;
					if (status !== outcome_q[0].st || served_position !== outcome_q[0].served ||
							move_distance !== outcome_q[0].travel ||
							total_distance !== outcome_q[0].total) begin
						errors++;
						if (errors <= 10)
							$display("mismatch: exp st %0d pos %0d dist %0d sum %0d, got %0d %0d %0d %0d",
								outcome_q[0].st, outcome_q[0].served, outcome_q[0].travel,
								outcome_q[0].total, status, served_position, move_distance,
								total_distance);
					end
					void'(outcome_q.pop_front());
				end
			end
			pop <= !receiver_idles();
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		logic [POS_BITS-1:0] base;
		int kind;
		int n;
		arst_n = 1'b0;
		for (int i = 0; i < 4; i++)
			status_cnt[i] = 0;
		for (int i = 0; i < ENTRIES; i++) begin
			slot_pos[i] = '0;
			slot_used[i] = 1'b0;
		end
		head_pos = '0;
		heading_up = 1'b1;
		travel_sum = '0;

		// directed: empty serve, extremes, head hit, a tie while heading down, duplicates
		add_item(OP_SERVE, 16'h1234);
		add_item(OP_INSERT, 16'hffff);
		add_item(OP_INSERT, 16'h0000);
		add_item(OP_SERVE, 16'h0000);
		add_item(OP_SERVE, 16'hffff);
		add_item(OP_SERVE, 16'h0000);
		add_item(OP_INSERT, 16'd100);
		add_item(OP_SERVE, 16'd0);
		add_item(OP_INSERT, 16'd90);
		add_item(OP_INSERT, 16'd110);
		add_item(OP_SERVE, 16'd0);
		add_item(OP_INSERT, 16'd100);
		add_item(OP_SERVE, 16'd0);
		add_item(OP_SERVE, 16'd0);
		add_item(OP_INSERT, 16'd90);
		add_item(OP_INSERT, 16'd90);
		add_item(OP_INSERT, 16'd90);
		add_item(OP_SERVE, 16'd0);
		add_item(OP_SERVE, 16'd0);
		add_item(OP_SERVE, 16'd0);
		add_item(OP_SERVE, 16'd0);
		add_item(OP_INSERT, 16'h5555);
		add_item(OP_INSERT, 16'haaaa);
		add_item(OP_SERVE, 16'hffff);

		while (request_q.size() < RANDOM_ITEMS + 24) begin
			kind = $urandom_range(0, 9);
			base = POS_BITS'($urandom_range(0, 65535));
			if (kind < 3) begin
				n = $urandom_range(60, 70);
				for (int i = 0; i < n; i++)
					add_item(OP_INSERT, pick_position(base));
			end else if (kind < 6) begin
				n = $urandom_range(20, 70);
				for (int i = 0; i < n; i++)
					add_item(OP_SERVE, POS_BITS'($urandom_range(0, 65535)));
			end else begin
				n = $urandom_range(10, 40);
				for (int i = 0; i < n; i++)
					add_item(logic'($urandom_range(0, 1)), pick_position(base));
			end
		end
		total_items = request_q.size();
		hold_at = total_items / 2;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		wait (request_q.size() == 0 && sent_cnt == total_items);
		@(posedge clk);
		while (push || outcome_q.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		$display("%0d items: %0d inserted, %0d served, %0d empty serves, %0d full drops",
			total_items, status_cnt[ST_INSERTED], status_cnt[ST_SERVED],
			status_cnt[ST_EMPTY], status_cnt[ST_FULL]);
		$display("%0d mismatches, final total distance %0d", errors, travel_sum);
		if (errors == 0 && outcome_q.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule
